/* sv/fde_pkg.sv */
// types, codes and helper functions shared by the format directive expander
// no dependencies; used by the controller, the datapath, the top level and the testbench
package fde_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_I       = 8'h69;
    localparam logic [7:0] CH_X_LOWER = 8'h78;
    localparam logic [7:0] CH_X_UPPER = 8'h58;
    localparam logic [7:0] CH_L       = 8'h6C;
    localparam logic [7:0] CH_B       = 8'h62;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_S       = 8'h73;

    localparam int DEC_STEPS  = 32;
    localparam int DEC_DIGITS = 10;
    localparam int CNT_W      = 5;
    localparam int STEP_W     = 5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEC,
        ST_TRIM,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        LD_NONE,
        LD_CHAR,
        LD_PCT,
        LD_ARGC,
        LD_HEX8,
        LD_HEX32,
        LD_HEX64,
        LD_BIN,
        LD_DEC
    } load_t;

    typedef struct packed {
        load_t load;
        logic  dabble;
        logic  trim;
        logic  emit;
    } cmd_t;

    typedef struct packed {
        logic dec_last;
        logic lead_zero;
        logic cnt_one;
        logic out_free;
    } stat_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10)
        begin
            ch = 8'h30 + {4'b0, nib};
        end
        else
        begin
            ch = 8'h37 + {4'b0, nib};
        end
        return ch;
    endfunction

endpackage

/* sv/fde_in_if.sv */
// input channel of the expander: format character and argument
// depends on nothing
interface fde_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  format_char;
    logic [63:0] argument_value;

    modport source (output valid, output format_char, output argument_value, input ready);
    modport sink (input valid, input format_char, input argument_value, output ready);
endinterface

/* sv/fde_out_if.sv */
// output channel of the expander: one ascii character per transaction
// depends on nothing
interface fde_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       is_last;

    modport source (output valid, output out_char, output is_last, input ready);
    modport sink (input valid, input out_char, input is_last, output ready);
endinterface

/* sv/fde_ctrl.sv */
// controller: decodes the format character, sequences conversion and emission
// depends on fde_pkg
module fde_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [7:0]            format_char,
    output logic                  in_ready,
    input  fde_pkg::stat_t        stat,
    output fde_pkg::cmd_t         cmd
);

    fde_pkg::state_t state_reg, state_next;
    logic            pending_reg, pending_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= fde_pkg::ST_IDLE;
            pending_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

    always_comb
    begin
        fde_pkg::load_t ld;
        state_next   = state_reg;
        pending_next = pending_reg;
        in_ready     = 1'b0;
        ld           = fde_pkg::LD_NONE;
        cmd.load     = fde_pkg::LD_NONE;
        cmd.dabble   = 1'b0;
        cmd.trim     = 1'b0;
        cmd.emit     = 1'b0;
        unique case (state_reg)
            fde_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (!pending_reg)
                begin
                    ld = (format_char == fde_pkg::CH_PERCENT) ? fde_pkg::LD_NONE
                                                              : fde_pkg::LD_CHAR;
                end
                else
                begin
                    unique case (format_char)
                        fde_pkg::CH_D, fde_pkg::CH_I: ld = fde_pkg::LD_DEC;
                        fde_pkg::CH_X_LOWER:          ld = fde_pkg::LD_HEX8;
                        fde_pkg::CH_X_UPPER:          ld = fde_pkg::LD_HEX32;
                        fde_pkg::CH_L:                ld = fde_pkg::LD_HEX64;
                        fde_pkg::CH_B:                ld = fde_pkg::LD_BIN;
                        fde_pkg::CH_C:                ld = fde_pkg::LD_ARGC;
                        fde_pkg::CH_S:                ld = fde_pkg::LD_NONE;
                        default:                      ld = fde_pkg::LD_PCT;
                    endcase
                end
                if (in_valid)
                begin
                    cmd.load     = ld;
                    pending_next = !pending_reg && (format_char == fde_pkg::CH_PERCENT);
                    if (ld == fde_pkg::LD_DEC)
                    begin
                        state_next = fde_pkg::ST_DEC;
                    end
                    else if (ld != fde_pkg::LD_NONE)
                    begin
                        state_next = fde_pkg::ST_EMIT;
                    end
                end
            end
            fde_pkg::ST_DEC:
            begin
                cmd.dabble = 1'b1;
                if (stat.dec_last)
                begin
                    state_next = fde_pkg::ST_TRIM;
                end
            end
            fde_pkg::ST_TRIM:
            begin
                if (stat.lead_zero && !stat.cnt_one)
                begin
                    cmd.trim = 1'b1;
                end
                else
                begin
                    state_next = fde_pkg::ST_EMIT;
                end
            end
            fde_pkg::ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.cnt_one)
                    begin
                        state_next = fde_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = fde_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/fde_datapath.sv */
// datapath: digit shift buffer, double-dabble converter and output register
// depends on fde_pkg
module fde_datapath
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     format_char,
    input  logic [63:0]    argument_value,
    input  fde_pkg::cmd_t  cmd,
    output fde_pkg::stat_t stat,
    input  logic           out_ready,
    output logic           out_valid,
    output logic [7:0]     out_char,
    output logic           out_last
);

    logic [63:0]                     buf_reg, buf_next;
    logic [4*fde_pkg::DEC_DIGITS-1:0] bcd_reg, bcd_next;
    logic                            raw_reg, raw_next;
    logic [fde_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [fde_pkg::STEP_W-1:0]      step_reg, step_next;
    logic                            out_valid_reg, out_valid_next;
    logic [7:0]                      out_char_reg, out_char_next;
    logic                            out_last_reg, out_last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg      <= buf_next;
        bcd_reg      <= bcd_next;
        raw_reg      <= raw_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign stat.dec_last  = (step_reg == fde_pkg::STEP_W'(fde_pkg::DEC_STEPS - 1));
    assign stat.lead_zero = (buf_reg[63:60] == 4'd0);
    assign stat.cnt_one   = (cnt_reg == fde_pkg::CNT_W'(1));
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        logic [63:0]                      bin_exp;
        logic [4*fde_pkg::DEC_DIGITS-1:0] bcd_adj;
        logic [4*fde_pkg::DEC_DIGITS+31:0] dd;
        buf_next       = buf_reg;
        bcd_next       = bcd_reg;
        raw_next       = raw_reg;
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        // one nibble per bit of the low byte, most significant first
        bin_exp = '0;
        for (int i = 0; i < 8; i++)
        begin
            bin_exp[32 + 4*i] = argument_value[i];
        end

        for (int k = 0; k < fde_pkg::DEC_DIGITS; k++)
        begin
            bcd_adj[4*k +: 4] = (bcd_reg[4*k +: 4] >= 4'd5) ? bcd_reg[4*k +: 4] + 4'd3
                                                           : bcd_reg[4*k +: 4];
        end
        dd = {bcd_adj, buf_reg[31:0]} << 1;

        unique case (cmd.load)
            fde_pkg::LD_NONE:
            begin
            end
            fde_pkg::LD_CHAR:
            begin
                buf_next = {format_char, 56'b0};
                cnt_next = fde_pkg::CNT_W'(1);
                raw_next = 1'b1;
            end
            fde_pkg::LD_PCT:
            begin
                buf_next = {fde_pkg::CH_PERCENT, format_char, 48'b0};
                cnt_next = fde_pkg::CNT_W'(2);
                raw_next = 1'b1;
            end
            fde_pkg::LD_ARGC:
            begin
                buf_next = {argument_value[7:0], 56'b0};
                cnt_next = fde_pkg::CNT_W'(1);
                raw_next = 1'b1;
            end
            fde_pkg::LD_HEX8:
            begin
                buf_next = {argument_value[7:0], 56'b0};
                cnt_next = fde_pkg::CNT_W'(2);
                raw_next = 1'b0;
            end
            fde_pkg::LD_HEX32:
            begin
                buf_next = {argument_value[31:0], 32'b0};
                cnt_next = fde_pkg::CNT_W'(8);
                raw_next = 1'b0;
            end
            fde_pkg::LD_HEX64:
            begin
                buf_next = argument_value;
                cnt_next = fde_pkg::CNT_W'(16);
                raw_next = 1'b0;
            end
            fde_pkg::LD_BIN:
            begin
                buf_next = bin_exp;
                cnt_next = fde_pkg::CNT_W'(8);
                raw_next = 1'b0;
            end
            fde_pkg::LD_DEC:
            begin
                buf_next  = {32'b0, argument_value[31:0]};
                bcd_next  = '0;
                step_next = '0;
                cnt_next  = fde_pkg::CNT_W'(fde_pkg::DEC_DIGITS);
                raw_next  = 1'b0;
            end
            default:
            begin
            end
        endcase

        if (cmd.dabble)
        begin
            bcd_next  = dd[4*fde_pkg::DEC_DIGITS+31:32];
            step_next = step_reg + fde_pkg::STEP_W'(1);
            if (stat.dec_last)
            begin
                buf_next = {dd[4*fde_pkg::DEC_DIGITS+31:32], 24'b0};
            end
            else
            begin
                buf_next = {32'b0, dd[31:0]};
            end
        end

        if (cmd.trim)
        begin
            buf_next = buf_reg << 4;
            cnt_next = cnt_reg - fde_pkg::CNT_W'(1);
        end

        if (cmd.emit)
        begin
            out_char_next  = raw_reg ? buf_reg[63:56] : fde_pkg::hex_char(buf_reg[63:60]);
            out_last_next  = stat.cnt_one;
            out_valid_next = 1'b1;
            buf_next       = raw_reg ? (buf_reg << 8) : (buf_reg << 4);
            cnt_next       = cnt_reg - fde_pkg::CNT_W'(1);
        end
    end

endmodule

/* sv/format_directive_expander_unit.sv */
// top level of the format directive expander: controller, datapath, channels
// depends on fde_pkg, fde_in_if, fde_out_if, fde_ctrl, fde_datapath
//
// One format character is taken at a time; the block accepts the next one only
// after every character of the current transaction has been loaded into the
// output register. A plain character or %c emits one character and an unknown
// directive two; %x, %X, %l and %b emit 2, 8, 16 or 8 digits. %d and %i run a
// double-dabble converter one bit per cycle over 32 shift steps, then trim 0 to
// 9 leading zeros and emit one character per remaining digit; trims and digits
// always add up to 10. A lone percent or %s emits nothing. A stalled output
// channel holds back the emission.
module format_directive_expander_unit
(
    input  logic       clk,
    input  logic       rst_n,
    fde_in_if.sink     in_chan,
    fde_out_if.source  out_chan
);

    fde_pkg::cmd_t  cmd;
    fde_pkg::stat_t stat;

    fde_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_chan.valid),
        .format_char (in_chan.format_char),
        .in_ready    (in_chan.ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    fde_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .format_char    (in_chan.format_char),
        .argument_value (in_chan.argument_value),
        .cmd            (cmd),
        .stat           (stat),
        .out_ready      (out_chan.ready),
        .out_valid      (out_chan.valid),
        .out_char       (out_chan.out_char),
        .out_last       (out_chan.is_last)
    );

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("character emitted while output register is occupied");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_chan.ready |-> !cmd.emit && !cmd.dabble && !cmd.trim)
        else $error("datapath busy while accepting input");

    a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && stat.cnt_one |=> in_chan.ready)
        else $error("input not ready after final character");

    a_dabble_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dabble |=> !cmd.emit)
        else $error("emission directly after conversion step");

endmodule

/* tb/tb_format_directive_expander_unit.sv */
// self-checking testbench of format_directive_expander_unit: directed and random format streams
// depends on fde_pkg, fde_in_if, fde_out_if and the format_directive_expander_unit rtl
module tb_format_directive_expander_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 2000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_TAIL  = 80;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } out_beat_t;

    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_t;

    logic clk;
    logic rst_n;

    fde_in_if  in_chan ();
    fde_out_if out_chan ();

    format_directive_expander_unit i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan)
    );

    out_beat_t  expected_chars[$];
    logic       pct_pending;
    int         mismatch_cnt;
    int         idle_cycles;
    rx_mode_t   rx_mode;
    int         hold_request;
    bit         tx_gaps;
    int         burst_left;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic logic [7:0] digit_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib > 4'd9)
        begin
            c = 8'h41 + 8'(nib - 4'd10);
        end
        else
        begin
            c = 8'h30 + 8'(nib);
        end
        return c;
    endfunction

    function automatic void push_char(input logic [7:0] c);
        out_beat_t beat;
        beat.ch   = c;
        beat.last = 1'b0;
        expected_chars.push_back(beat);
    endfunction

    function automatic void push_hex(input logic [63:0] v, input int digits);
        for (int k = digits - 1; k >= 0; k--)
        begin
            push_char(digit_char(v[4*k +: 4]));
        end
    endfunction

    // expected characters of one accepted format character
    function automatic void expand_format_char(input logic [7:0] ch, input logic [63:0] arg);
        int          before_cnt;
        logic [31:0] dec_val;
        logic [7:0]  dec_digits[10];
        int          n;
        before_cnt = expected_chars.size();
        if (!pct_pending)
        begin
            if (ch == fde_pkg::CH_PERCENT)
            begin
                pct_pending = 1'b1;
            end
            else
            begin
                push_char(ch);
            end
        end
        else
        begin
            pct_pending = 1'b0;
            case (ch)
                fde_pkg::CH_D, fde_pkg::CH_I:
                begin
                    dec_val = arg[31:0];
                    n = 0;
                    do
                    begin
                        dec_digits[n] = 8'h30 + 8'(dec_val % 32'd10);
                        dec_val = dec_val / 32'd10;
                        n++;
                    end
                    while (dec_val != 0);
                    for (int k = n - 1; k >= 0; k--)
                    begin
                        push_char(dec_digits[k]);
                    end
                end
                fde_pkg::CH_X_LOWER: push_hex({56'd0, arg[7:0]}, 2);
                fde_pkg::CH_X_UPPER: push_hex({32'd0, arg[31:0]}, 8);
                fde_pkg::CH_L:       push_hex(arg, 16);
                fde_pkg::CH_B:
                begin
                    for (int k = 7; k >= 0; k--)
                    begin
                        push_char(digit_char({3'd0, arg[k]}));
                    end
                end
                fde_pkg::CH_C:       push_char(arg[7:0]);
                fde_pkg::CH_S:       ;
                default:
                begin
                    push_char(fde_pkg::CH_PERCENT);
                    push_char(ch);
                end
            endcase
        end
        if (expected_chars.size() > before_cnt)
        begin
            expected_chars[expected_chars.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic logic [63:0] random_argument();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = 64'd0;
            1: v = '1;
            2: v = 64'd1 << $urandom_range(0, 63);
            3: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic [63:0] arg);
        int gap;
        in_chan.valid          <= 1'b1;
        in_chan.format_char    <= ch;
        in_chan.argument_value <= arg;
        @(posedge clk);
        while (!in_chan.ready)
        begin
            @(posedge clk);
        end
        expand_format_char(ch, arg);
        if (tx_gaps)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 8);
                gap = $urandom_range(1, 7);
                in_chan.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    task automatic send_directive(input logic [7:0] conv, input logic [63:0] arg);
        send_char(fde_pkg::CH_PERCENT, random_argument());
        send_char(conv, arg);
    endtask

    task automatic wait_drained();
        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_directed_cases();
        tx_gaps = 1'b0;
        rx_mode = RX_FREE;
        send_char(8'h00, '1);
        send_char(8'hFF, 64'd0);
        send_char(8'h41, {$urandom, $urandom});
        send_directive(fde_pkg::CH_D, 64'd0);
        send_directive(fde_pkg::CH_I, '1);
        send_directive(fde_pkg::CH_X_LOWER, 64'hFFFF_FFFF_FFFF_FFFF);
        send_directive(fde_pkg::CH_X_UPPER, 64'h0123_4567_89AB_CDEF);
        send_directive(fde_pkg::CH_L, 64'hFEDC_BA98_7654_3210);
        send_directive(fde_pkg::CH_B, 64'h0000_0000_0000_00A5);
        send_directive(fde_pkg::CH_C, 64'hFFFF_FFFF_FFFF_FF00);
        send_directive(fde_pkg::CH_S, '1);
        send_directive(fde_pkg::CH_PERCENT, 64'd0);
        send_directive(8'h00, 64'd0);
        send_directive(8'hFF, '1);
        wait_drained();
    endtask

    task automatic test_random_sequences(input int n_items);
        logic [7:0] conv_set[9];
        int         sent;
        conv_set = '{fde_pkg::CH_D, fde_pkg::CH_I, fde_pkg::CH_X_LOWER, fde_pkg::CH_X_UPPER,
                     fde_pkg::CH_L, fde_pkg::CH_B, fde_pkg::CH_C, fde_pkg::CH_S,
                     fde_pkg::CH_PERCENT};
        tx_gaps = 1'b1;
        sent = 0;
        while (sent < n_items)
        begin
            if (sent == n_items / 3)
            begin
                rx_mode = RX_PATTERN;
            end
            else if (sent == 2 * n_items / 3)
            begin
                rx_mode = RX_RANDOM;
            end
            if ($urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    send_directive(8'($urandom), random_argument());
                end
                else
                begin
                    send_directive(conv_set[$urandom_range(0, 8)], random_argument());
                end
                sent += 2;
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    send_char(fde_pkg::CH_PERCENT, random_argument());
                end
                else
                begin
                    send_char(8'($urandom), random_argument());
                end
                sent++;
            end
        end
        wait_drained();
    endtask

    task automatic test_output_stall();
        tx_gaps = 1'b0;
        rx_mode = RX_FREE;
        hold_request = LONG_HOLD;
        for (int k = 0; k < 6; k++)
        begin
            send_directive(fde_pkg::CH_L, {$urandom, $urandom});
        end
        send_directive(fde_pkg::CH_D, {$urandom, $urandom});
        wait_drained();
    endtask

    task automatic test_back_to_back();
        tx_gaps = 1'b0;
        rx_mode = RX_FREE;
        for (int k = 0; k < 10; k++)
        begin
            send_char(8'($urandom), {$urandom, $urandom});
            send_directive(fde_pkg::CH_C, {$urandom, $urandom});
        end
        wait_drained();
    endtask

    // output receiver
    initial
    begin
        int hold_left;
        int phase;
        hold_left = 0;
        phase = 0;
        out_chan.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            phase++;
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_chan.ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_RANDOM:  out_chan.ready <= ($urandom_range(0, 3) != 0);
                    RX_PATTERN: out_chan.ready <= (phase % 11 > 3) && (phase % 3 != 0);
                    default:    out_chan.ready <= 1'b1;
                endcase
            end
        end
    end

    // result checker
    initial
    begin
        out_beat_t want;
        mismatch_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_chan.valid && out_chan.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                    begin
                        $display("unexpected transaction: out_char=%h is_last=%b",
                                 out_chan.out_char, out_chan.is_last);
                    end
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_chan.out_char !== want.ch || out_chan.is_last !== want.last)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS)
                        begin
                            $display("mismatch: out_char exp %h got %h, is_last exp %b got %b",
                                     want.ch, out_chan.out_char, want.last, out_chan.is_last);
                        end
                    end
                end
            end
        end
    end

    // watchdog
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || !rst_n)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n                  <= 1'b0;
        in_chan.valid          <= 1'b0;
        in_chan.format_char    <= 8'd0;
        in_chan.argument_value <= 64'd0;
        pct_pending  = 1'b0;
        rx_mode      = RX_FREE;
        hold_request = 0;
        tx_gaps      = 1'b0;
        burst_left   = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_sequences(130);
        test_output_stall();
        test_back_to_back();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (mismatch_cnt == 0 && expected_chars.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
